// File: rtl/skvs_pkg.sv
`default_nettype none

package skvs_pkg;

   localparam int FIELD_BITS = 64;
   localparam int COUNT_BITS = 5;

   typedef enum logic {
      OP_PUT,
      OP_GET
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_CLOSED,
      STATUS_FULL,
      STATUS_MISSING
   } status_type;

   // broadcast command from the control stage to every cell
   typedef struct packed {
      logic insert;
      logic update;
   } cmd_type;

   // per-cell status handed to the next cell up the chain
   typedef struct packed {
      logic valid;
      logic gt;
   } link_type;

endpackage

`default_nettype wire

// File: rtl/skvs_req_if.sv
`default_nettype none

interface skvs_req_if import skvs_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic                  operation;
   logic [FIELD_BITS-1:0] key;
   logic [FIELD_BITS-1:0] value;

   modport source (output valid, output operation, output key, output value, input ready);
   modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/skvs_rsp_if.sv
`default_nettype none

interface skvs_rsp_if import skvs_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [FIELD_BITS-1:0] value_out;
   logic [COUNT_BITS-1:0] entry_count;

   modport source (output valid, output status, output value_out, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input value_out, input entry_count,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/sorted_key_value_store.sv
// Sorted key/value table built as a chain of record cells.
// req: one request per handshake; operation 0 puts (insert or update), 1 gets.
//   Only the top KEY_BYTES of key and top VALUE_BYTES of value are kept.
// rsp: one response per request with status (ok, closed, full, not found),
//   value_out (value on a successful get, else zero) and entry_count.
// csr: csr_write_enable loads csr_write_data[0] as the open flag; while it is
//   clear every request answers closed and the table is left alone.
// Flow: a request is registered in the request stage on acceptance; every cell
//   compares its key to it and shifts or loads in the same edge that registers
//   the response and raises rsp.valid; that edge waits while an untaken response is held.
// Intake: the single request stage ahead of the cell chain takes no new request
//   until the one it holds has been applied to the cells and the response register.
// Stall: while rsp.ready is low the response holds; one further request may
//   be accepted and waits in the request stage until the response is taken.
// Reset: the table empties and the flag clears at once; stored records are
//   not cleared and are never read until written.
`default_nettype none

module sorted_key_value_store import skvs_pkg::*; #(
   parameter int DEPTH       = 16,
   parameter int KEY_BYTES   = 8,
   parameter int VALUE_BYTES = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   skvs_req_if.sink                   req,
   skvs_rsp_if.source                 rsp,
   input  wire logic                  csr_write_enable,
   input  wire logic [FIELD_BITS-1:0] csr_write_data
);

   localparam int KW = 8 * KEY_BYTES;
   localparam int VW = 8 * VALUE_BYTES;
   localparam int CW = $clog2(DEPTH + 1);

   logic                  open_ff;
   logic                  s1_valid_ff;
   logic                  op_ff;
   logic [KW-1:0]         key_ff;
   logic [VW-1:0]         value_ff;
   logic [CW-1:0]         count_ff;
   logic                  rsp_valid_ff;
   status_type            status_ff;
   logic [FIELD_BITS-1:0] value_out_ff;
   logic [COUNT_BITS-1:0] entry_count_ff;

   logic                  exec;
   logic                  hit;
   logic                  full;
   logic                  is_put;
   cmd_type               cmd;
   logic [VW-1:0]         sel_value;
   status_type            status_in;
   logic [FIELD_BITS-1:0] value_out_in;
   logic [CW-1:0]         count_in;
   logic [31:0]           count_wide;

   logic [DEPTH-1:0]      eq;
   logic [DEPTH-1:0]      occupied;
   link_type              links      [DEPTH];
   logic [KW-1:0]         cell_key   [DEPTH];
   logic [VW-1:0]         cell_value [DEPTH];

   assign req.ready = !s1_valid_ff;
   assign exec      = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign hit       = |eq;
   assign full      = (count_ff == CW'(DEPTH));
   assign is_put    = (op_ff == OP_PUT);

   assign cmd.update = exec && open_ff && is_put && hit;
   assign cmd.insert = exec && open_ff && is_put && !hit && !full;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         link_type      prev_link;
         logic [KW-1:0] prev_key;
         logic [VW-1:0] prev_value;

         assign occupied[g] = (CW'(g) < count_ff);

         if (g == 0) begin : g_head
            assign prev_link.valid = 1'b1;
            assign prev_link.gt    = 1'b0;
            assign prev_key        = '0;
            assign prev_value      = '0;
         end else begin : g_body
            assign prev_link  = links[g-1];
            assign prev_key   = cell_key[g-1];
            assign prev_value = cell_value[g-1];
         end

         skvs_cell #(
            .KW (KW),
            .VW (VW)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .cmd_key    (key_ff),
            .cmd_value  (value_ff),
            .occupied   (occupied[g]),
            .prev_link  (prev_link),
            .prev_key   (prev_key),
            .prev_value (prev_value),
            .link       (links[g]),
            .key        (cell_key[g]),
            .value      (cell_value[g]),
            .eq         (eq[g])
         );
      end
   endgenerate

   // keys are unique, so at most one cell matches
   always_comb begin
      sel_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_value = sel_value | (eq[i] ? cell_value[i] : '0);
      end
   end

   always_comb begin
      value_out_in = '0;
      count_in     = count_ff;
      priority if (!open_ff) begin
         status_in = STATUS_CLOSED;
      end else if (is_put) begin
         status_in = (hit || !full) ? STATUS_OK : STATUS_FULL;
         count_in  = count_ff + CW'(cmd.insert);
      end else if (hit) begin
         status_in    = STATUS_OK;
         value_out_in = FIELD_BITS'(sel_value) << (FIELD_BITS - VW);
      end else begin
         status_in = STATUS_MISSING;
      end
   end

   assign count_wide = 32'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            open_ff <= csr_write_data[0];
         end
         if (req.valid && req.ready) begin
            s1_valid_ff <= 1'b1;
         end else if (exec) begin
            s1_valid_ff <= 1'b0;
         end
         if (exec) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= count_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         op_ff    <= req.operation;
         key_ff   <= req.key[FIELD_BITS-1 -: KW];
         value_ff <= req.value[FIELD_BITS-1 -: VW];
      end
      if (exec) begin
         status_ff      <= status_in;
         value_out_ff   <= value_out_in;
         entry_count_ff <= count_wide[COUNT_BITS-1:0];
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.value_out   = value_out_ff;
   assign rsp.entry_count = entry_count_ff;

endmodule

`default_nettype wire

// File: rtl/skvs_cell.sv
`default_nettype none

module skvs_cell import skvs_pkg::*; #(
   parameter int KW = 64,
   parameter int VW = 64
) (
   input  wire logic          clock,
   input  wire cmd_type       cmd,
   input  wire logic [KW-1:0] cmd_key,
   input  wire logic [VW-1:0] cmd_value,
   input  wire logic          occupied,
   input  wire link_type      prev_link,
   input  wire logic [KW-1:0] prev_key,
   input  wire logic [VW-1:0] prev_value,
   output link_type           link,
   output logic [KW-1:0]      key,
   output logic [VW-1:0]      value,
   output logic               eq
);

   logic [KW-1:0] key_ff;
   logic [VW-1:0] value_ff;
   logic          shift_in;
   logic          take_new_in;

   assign link.valid = occupied;
   assign link.gt    = occupied && (key_ff > cmd_key);
   assign eq         = occupied && (key_ff == cmd_key);
   assign key        = key_ff;
   assign value      = value_ff;

   // larger keys move up one slot; the first slot past the smaller keys takes the new record
   assign shift_in    = cmd.insert && prev_link.gt;
   assign take_new_in = cmd.insert && !prev_link.gt && prev_link.valid
                        && (!occupied || link.gt);

   always_ff @(posedge clock) begin
      if (shift_in) begin
         key_ff   <= prev_key;
         value_ff <= prev_value;
      end else if (take_new_in) begin
         key_ff   <= cmd_key;
         value_ff <= cmd_value;
      end else if (cmd.update && eq) begin
         value_ff <= cmd_value;
      end
   end

endmodule

`default_nettype wire

// File: tb/sorted_key_value_store_tb.sv
`timescale 1ns / 1ps

module sorted_key_value_store_tb;
   import skvs_pkg::*;

   localparam int DEPTH           = 16;
   localparam int KEY_BYTES       = 8;
   localparam int VALUE_BYTES     = 8;
   localparam int RANDOM_ITEMS    = 1920;
   localparam int CALM_TAIL       = 200;
   localparam int WATCHDOG_CYCLES = 2000;

   localparam logic [FIELD_BITS-1:0] KEY_MASK   = ~64'h0 << (64 - 8 * KEY_BYTES);
   localparam logic [FIELD_BITS-1:0] VALUE_MASK = ~64'h0 << (64 - 8 * VALUE_BYTES);
   localparam logic [FIELD_BITS-1:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [FIELD_BITS-1:0] PROBE_KEY  = 64'h1234_5678_9ABC_DEF0;

   typedef struct packed {
      status_type            status;
      logic [FIELD_BITS-1:0] value_out;
      logic [COUNT_BITS-1:0] entry_count;
   } table_reply_type;

   localparam table_reply_type NO_REPLY = '{STATUS_OK, 64'h0, 5'd0};

   typedef enum {ROW_REQUEST, ROW_OPEN, ROW_FILL} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      op_type                op;
      logic [FIELD_BITS-1:0] key;
      logic [FIELD_BITS-1:0] value;
      bit                    typed;
      table_reply_type       reply;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_write_enable;
   logic [FIELD_BITS-1:0] csr_write_data;

   skvs_req_if req_bus ();
   skvs_rsp_if rsp_bus ();

   sorted_key_value_store #(
      .DEPTH       (DEPTH),
      .KEY_BYTES   (KEY_BYTES),
      .VALUE_BYTES (VALUE_BYTES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the table
   logic [FIELD_BITS-1:0] stored_keys   [DEPTH];
   logic [FIELD_BITS-1:0] stored_values [DEPTH];
   int                    stored_count = 0;
   bit                    table_open   = 1'b0;

   table_reply_type expected_replies [$];
   bit              pending_typed = 1'b0;
   table_reply_type pending_reply = NO_REPLY;
   int              mismatch_count = 0;
   int              stall_cycles = 0;
   int              rsp_stall_left = 0;
   bit              idle_on = 1'b1;

   script_row_type script [24] = '{
      '{ROW_REQUEST, OP_PUT, 64'h1, 64'hDEAD_BEEF_0000_0001, 1'b1,
        '{STATUS_CLOSED, 64'h0, 5'd0}},
      '{ROW_REQUEST, OP_GET, 64'h1, 64'h0, 1'b1, '{STATUS_CLOSED, 64'h0, 5'd0}},
      '{ROW_OPEN, OP_PUT, 64'h0, 64'h1, 1'b0, NO_REPLY},
      '{ROW_REQUEST, OP_GET, 64'h0, ALL_ONES, 1'b1, '{STATUS_MISSING, 64'h0, 5'd0}},
      '{ROW_REQUEST, OP_PUT, ALL_ONES, ALL_ONES, 1'b1, '{STATUS_OK, 64'h0, 5'd1}},
      '{ROW_REQUEST, OP_PUT, 64'h0, 64'h0, 1'b1, '{STATUS_OK, 64'h0, 5'd2}},
      '{ROW_REQUEST, OP_GET, ALL_ONES, 64'h0, 1'b1, '{STATUS_OK, ALL_ONES, 5'd2}},
      '{ROW_REQUEST, OP_GET, 64'h0, 64'h0, 1'b1, '{STATUS_OK, 64'h0, 5'd2}},
      '{ROW_REQUEST, OP_PUT, ALL_ONES, 64'h0123_4567_89AB_CDEF, 1'b1,
        '{STATUS_OK, 64'h0, 5'd2}},
      '{ROW_REQUEST, OP_GET, ALL_ONES, 64'h0, 1'b1,
        '{STATUS_OK, 64'h0123_4567_89AB_CDEF, 5'd2}},
      // bytes after a zero byte still take part in the compare
      '{ROW_REQUEST, OP_PUT, 64'h4100_4200_0000_0000, 64'h5555_5555_5555_5555, 1'b1,
        '{STATUS_OK, 64'h0, 5'd3}},
      '{ROW_REQUEST, OP_PUT, 64'h4100_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
        '{STATUS_OK, 64'h0, 5'd4}},
      '{ROW_REQUEST, OP_GET, 64'h4100_4200_0000_0000, 64'h0, 1'b1,
        '{STATUS_OK, 64'h5555_5555_5555_5555, 5'd4}},
      '{ROW_REQUEST, OP_GET, 64'h4100_0000_0000_0001, 64'h0, 1'b1,
        '{STATUS_MISSING, 64'h0, 5'd4}},
      '{ROW_REQUEST, OP_PUT, 64'h8000_0000_0000_0000, 64'h1, 1'b0, NO_REPLY},
      '{ROW_FILL, OP_PUT, 64'h0, 64'h0, 1'b0, NO_REPLY},
      '{ROW_REQUEST, OP_PUT, PROBE_KEY, ALL_ONES, 1'b1, '{STATUS_FULL, 64'h0, 5'd16}},
      '{ROW_REQUEST, OP_PUT, ALL_ONES, 64'hFEDC_BA98_7654_3210, 1'b1,
        '{STATUS_OK, 64'h0, 5'd16}},
      '{ROW_REQUEST, OP_GET, ALL_ONES, 64'h0, 1'b1,
        '{STATUS_OK, 64'hFEDC_BA98_7654_3210, 5'd16}},
      '{ROW_REQUEST, OP_GET, PROBE_KEY, 64'h0, 1'b1, '{STATUS_MISSING, 64'h0, 5'd16}},
      '{ROW_OPEN, OP_PUT, 64'h0, 64'h0, 1'b0, NO_REPLY},
      '{ROW_REQUEST, OP_GET, ALL_ONES, 64'h0, 1'b1, '{STATUS_CLOSED, 64'h0, 5'd16}},
      '{ROW_REQUEST, OP_PUT, 64'h42, 64'h7, 1'b1, '{STATUS_CLOSED, 64'h0, 5'd16}},
      '{ROW_OPEN, OP_PUT, 64'h0, 64'h1, 1'b0, NO_REPLY}
   };

   function automatic table_reply_type table_apply(input op_type op,
                                                   input logic [FIELD_BITS-1:0] key_in,
                                                   input logic [FIELD_BITS-1:0] value_in);
      logic [FIELD_BITS-1:0] k;
      logic [FIELD_BITS-1:0] v;
      int                    slot;
      int                    pos;
      table_reply_type       r;
      k = key_in & KEY_MASK;
      v = value_in & VALUE_MASK;
      r = NO_REPLY;
      slot = -1;
      for (int i = 0; i < stored_count; i++) begin
         if (slot < 0 && stored_keys[i] == k) slot = i;
      end
      if (!table_open) begin
         r.status = STATUS_CLOSED;
      end else if (op == OP_PUT) begin
         if (slot >= 0) begin
            stored_values[slot] = v;
         end else if (stored_count >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            pos = stored_count;
            while (pos > 0 && stored_keys[pos-1] > k) begin
               stored_keys[pos]   = stored_keys[pos-1];
               stored_values[pos] = stored_values[pos-1];
               pos--;
            end
            stored_keys[pos]   = k;
            stored_values[pos] = v;
            stored_count++;
         end
      end else if (slot >= 0) begin
         r.value_out = stored_values[slot];
      end else begin
         r.status = STATUS_MISSING;
      end
      r.entry_count = COUNT_BITS'(stored_count);
      return r;
   endfunction

   task automatic note_mismatch(input string what, input table_reply_type want,
                                input table_reply_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected %0d %h %0d, got %0d %h %0d",
                  $time, what, want.status, want.value_out, want.entry_count,
                  got.status, got.value_out, got.entry_count);
   endtask

   task automatic push_request(input op_type op, input logic [FIELD_BITS-1:0] key,
                               input logic [FIELD_BITS-1:0] value, input bit typed,
                               input table_reply_type reply);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.key       <= key;
      req_bus.value     <= value;
      pending_typed = typed;
      pending_reply = reply;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // only while the table is quiet
   task automatic write_open_flag(input bit open_flag);
      req_bus.valid <= 1'b0;
      while (expected_replies.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= {$urandom, 31'($urandom_range(0, 32'h7FFF_FFFF)), open_flag};
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [FIELD_BITS-1:0] pick_key();
      logic [FIELD_BITS-1:0] k;
      k = {$urandom, $urandom};
      if (stored_count > 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: k = stored_keys[$urandom_range(0, stored_count - 1)];
            5, 6: k = stored_keys[$urandom_range(0, stored_count - 1)]
                      ^ (64'h1 << $urandom_range(0, 63));
            default: ;
         endcase
      end
      return k;
   endfunction

   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(0, 3);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      table_reply_type got;
      table_reply_type want;
      table_reply_type predicted;
      bit              moved;
      if (reset) begin
         stall_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_write_enable) table_open = csr_write_data[0];
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            got = {rsp_bus.status, rsp_bus.value_out, rsp_bus.entry_count};
            if (expected_replies.size() == 0) begin
               note_mismatch("response without request", NO_REPLY, got);
            end else begin
               want = expected_replies.pop_front();
               if (got !== want) note_mismatch("response mismatch", want, got);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            predicted = table_apply(op_type'(req_bus.operation), req_bus.key, req_bus.value);
            expected_replies.push_back(pending_typed ? pending_reply : predicted);
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_CYCLES) begin
            $display("sorted_key_value_store regression: fail");
            $finish;
         end
      end
   end

   initial begin
      logic [FIELD_BITS-1:0] fill_key;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_PUT;
      req_bus.key       <= '0;
      req_bus.value     <= '0;
      csr_write_enable  <= 1'b0;
      csr_write_data    <= '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (script[r]) begin
         case (script[r].kind)
            ROW_REQUEST: push_request(script[r].op, script[r].key, script[r].value,
                                      script[r].typed, script[r].reply);
            ROW_OPEN: write_open_flag(script[r].value[0]);
            ROW_FILL: begin
               while (stored_count < DEPTH) begin
                  fill_key = pick_key();
                  if ($urandom_range(0, 1) == 0) fill_key = {$urandom, $urandom};
                  if (fill_key == PROBE_KEY) fill_key = ~fill_key;
                  push_request(OP_PUT, fill_key, {$urandom, $urandom}, 1'b0, NO_REPLY);
               end
            end
            default: ;
         endcase
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0)
            idle_on = (n < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
         if (n % 240 == 120) write_open_flag(1'b0);
         if (n % 240 == 140) write_open_flag(1'b1);
         push_request(op_type'($urandom_range(0, 1)), pick_key(), {$urandom, $urandom},
                      1'b0, NO_REPLY);
      end

      req_bus.valid <= 1'b0;
      while (expected_replies.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && expected_replies.size() == 0)
         $display("sorted_key_value_store regression: pass");
      else
         $display("sorted_key_value_store regression: fail");
      $finish;
   end

endmodule

// File: filelist.f
rtl/skvs_pkg.sv
rtl/skvs_req_if.sv
rtl/skvs_rsp_if.sv
rtl/skvs_cell.sv
rtl/sorted_key_value_store.sv
tb/sorted_key_value_store_tb.sv
